@@ sv/fusp_pkg.sv @@
package fusp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_KEY_BYTE   = 3'd0;
    localparam logic [2:0] KIND_VALUE_BYTE = 3'd1;
    localparam logic [2:0] KIND_KEY_DONE   = 3'd2;
    localparam logic [2:0] KIND_VALUE_END  = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;

    localparam logic [15:0] KEY_LIMIT_RESET = 16'd1024;

    // Most results that one input byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [31:0] pos;
    } result_t;

    // All results of one input byte; last_idx is the count minus one
    typedef struct packed {
        logic [1:0]                    last_idx;
        result_t [MAX_RESULTS-1:0]     res;
    } bundle_t;

endpackage

@@ sv/fusp_front.sv @@
module fusp_front
    import fusp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        push,
    output bundle_t     push_bundle,
    input  logic        push_ready
);

    localparam logic [2:0] PH_KEY       = 3'd0;
    localparam logic [2:0] PH_VALUE     = 3'd1;
    localparam logic [2:0] PH_EXPECT_NL = 3'd2;
    localparam logic [2:0] PH_DONE      = 3'd3;
    localparam logic [2:0] PH_ERROR     = 3'd4;

    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    logic [2:0]  phase_reg,     phase_next;
    logic [1:0]  esc_cnt_reg,   esc_cnt_next;
    logic [7:0]  esc_first_reg, esc_first_next;
    logic [15:0] key_len_reg,   key_len_next;
    logic [31:0] val_pos_reg,   val_pos_next;
    logic [15:0] key_limit_reg;

    logic [1:0]  n;
    result_t [MAX_RESULTS-1:0] res;
    logic        do_fail, do_flush, do_mark, do_feed, consumed;
    logic [2:0]  mark_kind, byte_kind;
    logic [4:0]  hx;
    logic [4:0]  hx_first;
    logic [7:0]  c;
    logic        is_nl;

    assign s_ready  = push_ready;
    assign c        = s_data_byte;
    assign hx       = hex_val(c);
    assign hx_first = hex_val(esc_first_reg);
    assign is_nl    = (c == CH_CR) || (c == CH_LF);

    always_comb begin
        phase_next     = phase_reg;
        esc_cnt_next   = esc_cnt_reg;
        esc_first_next = esc_first_reg;
        key_len_next   = key_len_reg;
        val_pos_next   = val_pos_reg;
        n              = 2'd0;
        res            = '0;
        do_fail        = 1'b0;
        do_flush       = 1'b0;
        do_mark        = 1'b0;
        do_feed        = 1'b0;
        consumed       = 1'b0;
        mark_kind      = KIND_KEY_DONE;
        byte_kind      = (phase_reg == PH_KEY) ? KIND_KEY_BYTE : KIND_VALUE_BYTE;

        case (phase_reg)
            PH_KEY: begin
                if (c == CH_EQ) begin
                    do_flush   = 1'b1;
                    do_mark    = 1'b1;
                    mark_kind  = KIND_KEY_DONE;
                    phase_next = PH_VALUE;
                end else if (key_len_reg >= key_limit_reg) begin
                    do_fail = 1'b1;
                end else begin
                    key_len_next = key_len_reg + 16'd1;
                    do_feed      = 1'b1;
                end
            end
            PH_VALUE: begin
                if (c == CH_AMP || is_nl) begin
                    do_flush   = 1'b1;
                    do_mark    = 1'b1;
                    mark_kind  = KIND_VALUE_END;
                    phase_next = (c == CH_AMP) ? PH_KEY : PH_EXPECT_NL;
                end else begin
                    do_feed = 1'b1;
                end
            end
            PH_EXPECT_NL: begin
                if (is_nl) begin
                    phase_next = PH_DONE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            default: begin
                do_fail = 1'b1;
            end
        endcase

        if (do_fail) begin
            res[0]         = '{kind: KIND_ERROR, data: 8'd0, pos: 32'd0};
            n              = 2'd1;
            phase_next     = PH_ERROR;
            esc_cnt_next   = 2'd0;
            esc_first_next = 8'd0;
        end

        // A terminator or non-hex byte inside an escape drops it into the stream as typed
        if (do_feed && esc_cnt_reg != 2'd0) begin
            if (esc_cnt_reg == 2'd1 && hx[4]) begin
                esc_first_next = c;
                esc_cnt_next   = 2'd2;
                consumed       = 1'b1;
            end else if (esc_cnt_reg == 2'd2 && hx[4]) begin
                res[n]         = '{kind: byte_kind,
                                   data: {hx_first[3:0], hx[3:0]},
                                   pos: val_pos_next};
                n              = n + 2'd1;
                val_pos_next   = sat_inc(val_pos_next);
                esc_cnt_next   = 2'd0;
                esc_first_next = 8'd0;
                consumed       = 1'b1;
            end else begin
                do_flush = 1'b1;
            end
        end

        if (do_flush) begin
            if (esc_cnt_reg != 2'd0) begin
                res[n]       = '{kind: byte_kind, data: CH_PCT, pos: val_pos_next};
                n            = n + 2'd1;
                val_pos_next = sat_inc(val_pos_next);
            end
            if (esc_cnt_reg == 2'd2) begin
                res[n]       = '{kind: byte_kind, data: esc_first_reg, pos: val_pos_next};
                n            = n + 2'd1;
                val_pos_next = sat_inc(val_pos_next);
            end
            esc_cnt_next   = 2'd0;
            esc_first_next = 8'd0;
        end

        if (do_mark) begin
            res[n]       = '{kind: mark_kind, data: 8'd0, pos: val_pos_next};
            n            = n + 2'd1;
            val_pos_next = 32'd0;
            key_len_next = 16'd0;
        end

        if (do_feed && !consumed) begin
            if (c == CH_PCT) begin
                esc_cnt_next = 2'd1;
            end else begin
                res[n]       = '{kind: byte_kind,
                                 data: (c == CH_PLUS) ? CH_SPACE : c,
                                 pos: val_pos_next};
                n            = n + 2'd1;
                val_pos_next = sat_inc(val_pos_next);
            end
        end
    end

    assign push                 = s_valid && s_ready && (n != 2'd0);
    assign push_bundle.res      = res;
    assign push_bundle.last_idx = n - 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_KEY;
            esc_cnt_reg   <= 2'd0;
            esc_first_reg <= 8'd0;
            key_len_reg   <= 16'd0;
            val_pos_reg   <= 32'd0;
            key_limit_reg <= KEY_LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                key_limit_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                phase_reg     <= phase_next;
                esc_cnt_reg   <= esc_cnt_next;
                esc_first_reg <= esc_first_next;
                key_len_reg   <= key_len_next;
                val_pos_reg   <= val_pos_next;
            end
        end
    end

endmodule

@@ sv/fusp_queue.sv @@
module fusp_queue
    import fusp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_bundle,
    output logic    push_ready,
    input  logic    pop,
    output logic    pop_valid,
    output bundle_t pop_bundle
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_bundle = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_bundle;
        end
    end

    // Pointers wrap at DEPTH, so any depth of two or more works
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/fusp_back.sv @@
module fusp_back
    import fusp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    input  bundle_t     pop_bundle,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic [31:0] m_position,
    output logic        m_last
);

    logic        cur_valid_reg;
    logic [1:0]  idx_reg;
    bundle_t     cur_reg;
    logic        at_last, done;
    result_t     cur_res;

    assign at_last = (idx_reg == cur_reg.last_idx);
    assign done    = cur_valid_reg && m_ready && at_last;
    assign pop     = pop_valid && (!cur_valid_reg || done);
    assign cur_res = cur_reg.res[idx_reg];

    assign m_valid    = cur_valid_reg;
    assign m_kind     = cur_res.kind;
    assign m_out_byte = cur_res.data;
    assign m_position = cur_res.pos;
    assign m_last     = at_last;

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= pop_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            if (pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end else if (done) begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= 2'd0;
            end else if (cur_valid_reg && m_ready) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

@@ sv/form_urlencoded_stream_parser.sv @@
// URL-encoded form body parser. One raw byte enters per transaction on the
// s_ channel; each byte yields zero to three results on the m_ channel:
// decoded key/value bytes with their offset, key-complete and value-end
// marks (position = decoded length), or an error (position 0). %HH and '+'
// are unescaped; broken or unfinished escapes come out literally. After a
// CR/LF terminator exactly one more CR or LF ends the body; any other byte
// there, a key over key_limit raw bytes, or any byte after the body ends
// gives an error result. m_last flags the final result of each input byte.
// Rate: the front decodes one byte per cycle while the queue has room and
// files its results as one bundle in a QUEUE_DEPTH-entry queue; the back
// sends one result per cycle while m_ready is high; throughput is one byte per
// cycle while bytes average one result or less, k transfers per k-result byte.
// Results are registered in the queue, then in the back. The user must write
// key_limit via cfg_wr_en/cfg_wr_data only while idle; not enforced by the block.
module form_urlencoded_stream_parser
    import fusp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic [31:0] m_position,
    output logic        m_last
);

    // front -> queue
    logic    push, push_ready;
    bundle_t push_bundle;
    // queue -> back
    logic    pop, pop_valid;
    bundle_t pop_bundle;

    // Decode and parse state; one bundle per accepted byte with results
    fusp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push        (push),
        .push_bundle (push_bundle),
        .push_ready  (push_ready)
    );

    // Absorbs bursts of multi-result bytes
    fusp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .push_ready  (push_ready),
        .pop         (pop),
        .pop_valid   (pop_valid),
        .pop_bundle  (pop_bundle)
    );

    // Serializes a bundle, one result per transaction
    fusp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_bundle (pop_bundle),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_byte (m_out_byte),
        .m_position (m_position),
        .m_last     (m_last)
    );

    // Error results carry no byte and no position and stand alone
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERROR |->
            m_out_byte == 8'd0 && m_position == 32'd0 && m_last)
        else $error("error result with payload or not last");

    // Key-complete and value-end marks always close their byte's results
    a_mark_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_KEY_DONE || m_kind == KIND_VALUE_END) |-> m_last)
        else $error("mark result not last of its byte");

    // Remaining results of a byte follow without a gap
    a_bundle_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("result bundle broken off");

endmodule
